// ===== design/morse_pkg.sv =====
// ----------------------------------------------------------------------------
// morse_pkg
// shared constants, types, letter table and microcode for the morse encoder
// ----------------------------------------------------------------------------
package morse_pkg;

  localparam int CHAR_W = 8;
  localparam int DOT_W  = 20;
  localparam int DUR_W  = 22;
  localparam int CNT_W  = 3;
  localparam int PAT_W  = 4;
  localparam int PC_W   = 2;

  localparam logic [DOT_W-1:0]  DOT_RESET = DOT_W'(100000);
  localparam logic [CHAR_W-1:0] CHAR_UP_A = CHAR_W'(8'h41);
  localparam logic [CHAR_W-1:0] CHAR_UP_Z = CHAR_W'(8'h5A);
  localparam logic [CHAR_W-1:0] CHAR_LO_A = CHAR_W'(8'h61);
  localparam logic [CHAR_W-1:0] CHAR_LO_Z = CHAR_W'(8'h7A);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // microcode program steps
  localparam logic [PC_W-1:0] PC_GAP_PRE  = 2'd0;
  localparam logic [PC_W-1:0] PC_MARK     = 2'd1;
  localparam logic [PC_W-1:0] PC_GAP_POST = 2'd2;

  // one control word of the program
  typedef struct packed {
    logic led_on;     // level of the segment
    logic dur_dash;   // duration follows element (dot or dash)
    logic last_elem;  // marks last when the element is the final one
    logic end_elem;   // element done: jump to step 0 or finish
  } ucode_t;

  // control handed from sequencer to datapath
  typedef struct packed {
    logic led_on;
    logic dur_dash;
    logic last_seg;
    logic elem_next;
  } ctrl_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_GAP_PRE:  w = '{led_on: 1'b0, dur_dash: 1'b0, last_elem: 1'b0, end_elem: 1'b0};
      PC_MARK:     w = '{led_on: 1'b1, dur_dash: 1'b1, last_elem: 1'b0, end_elem: 1'b0};
      PC_GAP_POST: w = '{led_on: 1'b0, dur_dash: 1'b0, last_elem: 1'b1, end_elem: 1'b1};
      default:     w = '{led_on: 1'b0, dur_dash: 1'b0, last_elem: 1'b1, end_elem: 1'b1};
    endcase
    return w;
  endfunction

  // bits 6..4 element count, bits 3..0 pattern (1 = dash, first element highest)
  function automatic logic [CNT_W+PAT_W-1:0] letter_code(input logic [4:0] idx);
    logic [CNT_W+PAT_W-1:0] c;
    unique case (idx)
      5'd0:    c = 7'h21;
      5'd1:    c = 7'h48;
      5'd2:    c = 7'h4A;
      5'd3:    c = 7'h34;
      5'd4:    c = 7'h10;
      5'd5:    c = 7'h42;
      5'd6:    c = 7'h36;
      5'd7:    c = 7'h40;
      5'd8:    c = 7'h20;
      5'd9:    c = 7'h47;
      5'd10:   c = 7'h35;
      5'd11:   c = 7'h44;
      5'd12:   c = 7'h23;
      5'd13:   c = 7'h22;
      5'd14:   c = 7'h37;
      5'd15:   c = 7'h46;
      5'd16:   c = 7'h4D;
      5'd17:   c = 7'h32;
      5'd18:   c = 7'h30;
      5'd19:   c = 7'h11;
      5'd20:   c = 7'h31;
      5'd21:   c = 7'h41;
      5'd22:   c = 7'h33;
      5'd23:   c = 7'h49;
      5'd24:   c = 7'h4B;
      5'd25:   c = 7'h4C;
      default: c = 7'h10;
    endcase
    return c;
  endfunction

endpackage

// ===== design/morse_seq.sv =====
// ----------------------------------------------------------------------------
// morse_seq
// step counter and microcode table that drive the segment datapath
// ----------------------------------------------------------------------------
module morse_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                step,
  input  logic                is_final,
  output morse_pkg::ctrl_t    ctrl
);

  logic [morse_pkg::PC_W-1:0] pc_r;
  logic [morse_pkg::PC_W-1:0] pc_nxt;
  morse_pkg::ucode_t          word;

  assign word = morse_pkg::ucode_rom(pc_r);

  always_comb begin
    ctrl.led_on    = word.led_on;
    ctrl.dur_dash  = word.dur_dash;
    ctrl.last_seg  = word.last_elem & is_final;
    ctrl.elem_next = word.end_elem & ~is_final;
  end

  always_comb begin
    pc_nxt = pc_r;
    if (start) begin
      pc_nxt = morse_pkg::PC_GAP_PRE;
    end else if (step) begin
      if (word.end_elem) begin
        pc_nxt = morse_pkg::PC_GAP_PRE;
      end else begin
        pc_nxt = pc_r + morse_pkg::PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= morse_pkg::PC_GAP_PRE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== design/morse_letter_encoder.sv =====
// ----------------------------------------------------------------------------
// morse_letter_encoder
// letters to timed on/off morse segments
// ----------------------------------------------------------------------------
// Each accepted letter is loaded into the element registers and then produces
// three segments per element, one segment per cycle into the output register
// while the result side keeps taking words; any other character is taken
// with no output. The microcode sequencer issues one segment per step.
// A new character is taken once the final segment has been loaded, while it
// may still wait at the output. Duration is the dot length (zero counts as
// one) or three dot lengths for the on part of a dash.
module morse_letter_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] led_on, [22:1] duration, [23] zero
  output logic        out_tuser,  // [0] last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data    // dot_length
);

  localparam int CW = morse_pkg::CNT_W;
  localparam int PW = morse_pkg::PAT_W;

  morse_pkg::state_t             state_r, state_nxt;
  logic [morse_pkg::DOT_W-1:0]   dot_r;
  logic [morse_pkg::DOT_W-1:0]   unit_r;
  logic [morse_pkg::DUR_W-1:0]   dash_r;
  logic [CW-1:0]                 rem_r;
  logic [PW-1:0]                 pat_r;
  logic                          out_valid_r;
  logic                          out_led_r;
  logic [morse_pkg::DUR_W-1:0]   out_dur_r;
  logic                          out_last_r;

  logic                          in_acc;
  logic                          is_up, is_lo, is_letter;
  logic [morse_pkg::CHAR_W-1:0]  idx_full;
  logic [CW+PW-1:0]              code;
  logic [CW-1:0]                 cnt;
  logic [PW-1:0]                 pat_al;
  logic [morse_pkg::DOT_W-1:0]   unit_v;
  logic                          slot_free;
  logic                          load_seg;
  logic                          start;
  morse_pkg::ctrl_t              ctrl;

  // input decode
  assign is_up     = (in_tdata >= morse_pkg::CHAR_UP_A) && (in_tdata <= morse_pkg::CHAR_UP_Z);
  assign is_lo     = (in_tdata >= morse_pkg::CHAR_LO_A) && (in_tdata <= morse_pkg::CHAR_LO_Z);
  assign is_letter = is_up | is_lo;
  assign idx_full  = is_up ? (in_tdata - morse_pkg::CHAR_UP_A)
                           : (in_tdata - morse_pkg::CHAR_LO_A);
  assign code      = morse_pkg::letter_code(idx_full[4:0]);
  assign cnt       = code[CW+PW-1:PW];
  assign pat_al    = code[PW-1:0] << (PW - int'(cnt));
  assign unit_v    = (dot_r == '0) ? morse_pkg::DOT_W'(1) : dot_r;

  assign in_acc    = in_tvalid & in_tready;
  assign start     = in_acc & is_letter;
  assign slot_free = ~out_valid_r | out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      morse_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = morse_pkg::ST_RUN;
        end
      end
      morse_pkg::ST_RUN: begin
        if (slot_free && ctrl.last_seg) begin
          state_nxt = morse_pkg::ST_IDLE;
        end
      end
      default: state_nxt = morse_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    load_seg  = 1'b0;
    unique case (state_r)
      morse_pkg::ST_IDLE: in_tready = 1'b1;
      morse_pkg::ST_RUN:  load_seg  = slot_free;
      default: begin
        in_tready = 1'b0;
        load_seg  = 1'b0;
      end
    endcase
  end

  morse_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .step     (load_seg),
    .is_final (rem_r == CW'(1)),
    .ctrl     (ctrl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= morse_pkg::ST_IDLE;
      dot_r       <= morse_pkg::DOT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        dot_r <= cfg_data;
      end
      if (load_seg) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // element datapath
  always_ff @(posedge clk) begin
    if (start) begin
      unit_r <= unit_v;
      dash_r <= {2'b00, unit_v} + {1'b0, unit_v, 1'b0};
      rem_r  <= cnt;
      pat_r  <= pat_al;
    end else if (load_seg && ctrl.elem_next) begin
      rem_r <= rem_r - CW'(1);
      pat_r <= {pat_r[PW-2:0], 1'b0};
    end
    if (load_seg) begin
      out_led_r  <= ctrl.led_on;
      out_dur_r  <= (ctrl.dur_dash && pat_r[PW-1]) ? dash_r : {2'b00, unit_r};
      out_last_r <= ctrl.last_seg;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_dur_r, out_led_r};
  assign out_tuser  = out_last_r;

endmodule

// ===== design/morse_chk.sv =====
// ----------------------------------------------------------------------------
// morse_chk
// port-level checks for the morse encoder, bound to the top level
// ----------------------------------------------------------------------------
module morse_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  logic letter;
  assign letter = ((in_tdata >= morse_pkg::CHAR_UP_A) && (in_tdata <= morse_pkg::CHAR_UP_Z)) ||
                  ((in_tdata >= morse_pkg::CHAR_LO_A) && (in_tdata <= morse_pkg::CHAR_LO_Z));

  // stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // a letter busies the input side
  a_letter_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && letter |=> !in_tready)
    else $error("input taken during a letter");

  // no segment of zero length
  a_dur_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[22:1] != 22'd0))
    else $error("zero segment duration");

  // last word is always an off gap
  a_last_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[0])
    else $error("last segment is on");

  // mid-character word means the character is still running
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> !in_tready)
    else $error("input ready before character finished");

endmodule

bind morse_letter_encoder morse_chk u_morse_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/sv/morse_letter_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// morse_letter_encoder_tb
// self-checking bench for the letter to morse segment encoder
// ----------------------------------------------------------------------------
// Characters go into the stream input and each returned segment is compared
// with a queue filled by a local model of the letter table and segment
// timing. The run covers the reset dot length, the dot length extremes
// including zero, non-letter codes, random traffic, and idle and stall mixes
// on both sides.
module morse_letter_encoder_tb;

  localparam int CLK_HALF    = 4;
  localparam int SETTLE      = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [morse_pkg::DOT_W-1:0] DOT_MAX = {morse_pkg::DOT_W{1'b1}};
  localparam byte DASH = "-";

  typedef struct packed {
    logic                        led_on;
    logic [morse_pkg::DUR_W-1:0] duration;
    logic                        last;
  } segment_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] char_code
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [23:0] out_tdata;       // [0] led_on, [22:1] duration, [23] zero
  logic        out_tuser;       // [0] last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [19:0] cfg_data = '0;   // dot_length

  string morse_table [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };

  segment_t                    pending_segments[$];
  segment_t                    want_seg;
  logic [morse_pkg::DOT_W-1:0] dot_length_now = morse_pkg::DOT_RESET;
  int                          send_idle_pct = 0;
  int                          recv_stall_pct = 0;
  int                          error_count = 0;
  int                          chars_sent = 0;
  int                          letters_sent = 0;
  int                          segments_checked = 0;
  int                          cycle_count = 0;

  morse_letter_encoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at segment %0d: %s got %0d, expected %0d",
             segments_checked, what, got, want);
    error_count++;
  endtask

  // segments of one character at the current dot length
  task automatic expand_letter(input logic [7:0] c);
    int                          idx;
    int                          n;
    logic [morse_pkg::DUR_W-1:0] unit;
    segment_t                    seg;
    if (c >= morse_pkg::CHAR_UP_A && c <= morse_pkg::CHAR_UP_Z) begin
      idx = int'(c - morse_pkg::CHAR_UP_A);
    end else if (c >= morse_pkg::CHAR_LO_A && c <= morse_pkg::CHAR_LO_Z) begin
      idx = int'(c - morse_pkg::CHAR_LO_A);
    end else begin
      return;
    end
    letters_sent++;
    unit = (dot_length_now == '0) ? morse_pkg::DUR_W'(1) : morse_pkg::DUR_W'(dot_length_now);
    n = morse_table[idx].len();
    for (int i = 0; i < n; i++) begin
      seg.led_on = 1'b0;
      seg.duration = unit;
      seg.last = 1'b0;
      pending_segments.push_back(seg);
      seg.led_on = 1'b1;
      seg.duration = (morse_table[idx][i] == DASH) ? morse_pkg::DUR_W'(unit * 3) : unit;
      pending_segments.push_back(seg);
      seg.led_on = 1'b0;
      seg.duration = unit;
      seg.last = (i == n - 1);
      pending_segments.push_back(seg);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_segments.size() == 0) begin
        report_mismatch("segment with none pending, word", out_tdata, 0);
      end else begin
        want_seg = pending_segments.pop_front();
        if (out_tdata[0] !== want_seg.led_on)
          report_mismatch("led_on", out_tdata[0], want_seg.led_on);
        if (out_tdata[22:1] !== want_seg.duration)
          report_mismatch("duration", out_tdata[22:1], want_seg.duration);
        if (out_tuser !== want_seg.last)
          report_mismatch("last", out_tuser, want_seg.last);
        if (out_tdata[23] !== 1'b0)
          report_mismatch("pad bit", out_tdata[23], 0);
      end
      segments_checked++;
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
    expand_letter(c);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_segments.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_dot_length(input logic [morse_pkg::DOT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dot_length_now = value;
  endtask

  function automatic logic [7:0] random_char();
    if ($urandom_range(99) < 85)
      return ($urandom_range(1) ? morse_pkg::CHAR_UP_A : morse_pkg::CHAR_LO_A)
             + 8'($urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  task automatic test_reset_dot_length();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_char("A");
    send_char("Z");
    send_char("a");
    send_char("z");
    send_char("E");
    send_char("t");
    wait_drained();
  endtask

  task automatic test_non_letters();
    send_char(8'h00);
    send_char(morse_pkg::CHAR_UP_A - 8'd1);
    send_char(morse_pkg::CHAR_UP_Z + 8'd1);
    send_char(morse_pkg::CHAR_LO_A - 8'd1);
    send_char(morse_pkg::CHAR_LO_Z + 8'd1);
    send_char(8'hFF);
    send_char(morse_pkg::CHAR_UP_A | 8'h80);
    send_char("J");
    wait_drained();
  endtask

  task automatic test_dot_length_extremes();
    write_dot_length(morse_pkg::DOT_W'(1));
    send_char("Q");
    wait_drained();
    write_dot_length(DOT_MAX);
    send_char("y");
    wait_drained();
    write_dot_length('0);
    send_char("B");
    send_char("o");
    wait_drained();
  endtask

  task automatic run_traffic(input logic [morse_pkg::DOT_W-1:0] dot, input int idle_pct,
                             input int stall_pct, input int count, input bit pause_midway);
    write_dot_length(dot);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) wait_drained();
      send_char(random_char());
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    run_traffic(morse_pkg::DOT_W'($urandom_range(2, DOT_MAX)), 0, 0, 45, 1'b0);
    run_traffic(morse_pkg::DOT_W'(1), 72, 0, 45, 1'b1);
    run_traffic(DOT_MAX, 0, 72, 45, 1'b0);
    run_traffic('0, 12, 12, 45, 1'b0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_dot_length();
    test_non_letters();
    test_dot_length_extremes();
    test_random_traffic();
    $display("sent %0d characters (%0d letters), checked %0d segments",
             chars_sent, letters_sent, segments_checked);
    $display({"dot lengths: reset value, one, zero, full scale and random; ",
              "idle and stall mixes on both sides"});
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
